@@ rtl/core/bcs_pkg.sv @@
package bcs_pkg;

    // Default sizes for the top level parameters
    localparam int DEF_DISPLAY_DIGITS = 6;
    localparam int DEF_COUNT_WIDTH    = 27;
    localparam int DEF_QUEUE_DEPTH    = 2;

    // Limit register
    localparam int              LIMIT_W     = 27;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 27'd99999999;

    // Packed display word, 8 bits per digit, room for eight digits
    localparam int SEG_WORD_W = 64;
    localparam int SEG_W      = 8;

    // Reciprocal of ten for 32-bit operands: q = (v * RECIP_TEN) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Key bit positions in the edge field
    localparam int KEY_ADD   = 0;
    localparam int KEY_CLEAR = 1;
    localparam int KEY_HALT  = 3;

    // Status that travels with each beat
    typedef struct packed {
        logic led;
        logic halted;
    } t_flags;

    // Largest value the display can show
    function automatic logic [63:0] display_cap(input int digits);
        logic [63:0] cap;
        cap = 64'd1;
        for (int d = 0; d < 8; d++) begin
            if (d < digits) begin
                cap = cap * 64'd10;
            end
        end
        return cap - 64'd1;
    endfunction

    // Seven-segment code of one decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/bcs_front.sv @@
module bcs_front
    import bcs_pkg::*;
#(
    parameter int DISPLAY_DIGITS = DEF_DISPLAY_DIGITS,
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // event channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_button_edges,
    input  logic [3:0]             i_switches,
    // limit register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LIMIT_W-1:0]     i_cfg_data,
    // push side of the queue
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [COUNT_WIDTH-1:0] o_value,
    output t_flags                 o_flags
);

    localparam int          MW          = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [63:0] DISPLAY_CAP = display_cap(DISPLAY_DIGITS);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_stopped, n_stopped;
    logic [LIMIT_W-1:0]     r_limit;
    logic [COUNT_WIDTH:0]   w_sum;
    logic                   w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !i_push_ready;
    assign w_accept    = i_valid && i_push_ready;

    // Saturating add of the switches
    assign w_sum = {1'b0, r_count} + (COUNT_WIDTH + 1)'(i_switches);

    // Apply the keys in priority order
    always_comb begin
        n_count   = r_count;
        n_stopped = r_stopped;
        if (!r_stopped) begin
            if (i_button_edges[KEY_ADD]) begin
                if (MW'(r_count) < MW'(r_limit)) begin
                    n_count = w_sum[COUNT_WIDTH] ? '1 : w_sum[COUNT_WIDTH-1:0];
                end
            end else if (i_button_edges[KEY_CLEAR]) begin
                n_count = '0;
            end else if (i_button_edges[KEY_HALT]) begin
                n_stopped = 1'b1;
            end
        end
    end

    // Classify the beat for the display path
    always_comb begin
        o_push_valid   = w_accept;
        o_flags.halted = n_stopped;
        o_flags.led    = !n_stopped && (MW'(n_count) > MW'(r_limit));
        o_count        = n_stopped ? '0 : n_count;
        if (n_stopped) begin
            o_value = '0;
        end else if (64'(n_count) > DISPLAY_CAP) begin
            o_value = COUNT_WIDTH'(DISPLAY_CAP);
        end else begin
            o_value = n_count;
        end
    end

    // Hold count, halt flag and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_limit   <= LIMIT_RESET;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_stopped <= n_stopped;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

endmodule

@@ rtl/core/bcs_queue.sv @@
module bcs_queue
    import bcs_pkg::*;
#(
    parameter int DATA_W = 2 * DEF_COUNT_WIDTH + 2,
    parameter int DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              w_push, w_pop;

    assign o_push_ready = (r_fill != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/bcs_digit.sv @@
module bcs_digit
    import bcs_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int DIGIT_INDEX = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COUNT_WIDTH-1:0] i_value,
    input  logic [SEG_WORD_W-1:0]  i_segs,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  t_flags                 i_flags,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_WIDTH-1:0] o_value,
    output logic [SEG_WORD_W-1:0]  o_segs,
    output logic [COUNT_WIDTH-1:0] o_count,
    output t_flags                 o_flags
);

    logic                   r_valid;
    logic [COUNT_WIDTH-1:0] r_value;
    logic [SEG_WORD_W-1:0]  r_segs;
    logic [COUNT_WIDTH-1:0] r_count;
    t_flags                 r_flags;

    logic [31:0]             w_wide;
    logic [63:0]             w_prod;
    logic [63-RECIP_SHIFT:0] w_quot;
    logic [31:0]             w_rem;
    logic [SEG_WORD_W-1:0]   n_segs;
    logic                    w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Split off the lowest decimal digit by reciprocal multiply
    assign w_wide = 32'(i_value);
    assign w_prod = 64'(w_wide) * 64'(RECIP_TEN);
    assign w_quot = w_prod[63:RECIP_SHIFT];
    assign w_rem  = w_wide - ((32'(w_quot) << 3) + (32'(w_quot) << 1));
    assign n_segs = i_segs | (SEG_WORD_W'(seg_code(w_rem[3:0])) << (SEG_W * DIGIT_INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the beat until the next stage takes it
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value <= COUNT_WIDTH'(w_quot);
            r_segs  <= n_segs;
            r_count <= i_count;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_segs  = r_segs;
    assign o_count = r_count;
    assign o_flags = r_flags;

endmodule

@@ rtl/core/button_counter_seven_segment_top.sv @@
// Button counter with seven-segment display. Each accepted beat is one button edge event;
// key 0 adds the switches while the count is below the limit, else key 1 clears it, else
// key 3 halts the block, and every event returns one beat with the packed segment codes
// (units lowest), the LED, the count and the halt flag. A new event is taken every cycle
// unless o_stall is high: the count update is one add and compare in the front, and the
// decimal split runs one digit per pipeline stage behind a short queue. Each beat is
// registered in the queue and each digit stage. The limit register is written through the
// cfg channel, which is always ready, and should only change while the block is idle.
module button_counter_seven_segment_top
    import bcs_pkg::*;
#(
    parameter int DISPLAY_DIGITS = DEF_DISPLAY_DIGITS,
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // event channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_button_edges,
    input  logic [3:0]             i_switches,
    // limit register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LIMIT_W-1:0]     i_cfg_data,
    // display channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_segments_low,
    output logic [15:0]            o_segments_high,
    output logic                   o_led,
    output logic [COUNT_WIDTH-1:0] o_count_value,
    output logic                   o_halted
);

    localparam int FLAGS_W = $bits(t_flags);
    localparam int DATA_W  = 2 * COUNT_WIDTH + FLAGS_W;

    logic                   w_push_valid, w_push_ready;
    logic [COUNT_WIDTH-1:0] w_push_count, w_push_value;
    t_flags                 w_push_flags;
    logic [DATA_W-1:0]      w_pop_data;

    logic                   w_valid [DISPLAY_DIGITS+1];
    logic                   w_ready [DISPLAY_DIGITS+1];
    logic [COUNT_WIDTH-1:0] w_value [DISPLAY_DIGITS+1];
    logic [SEG_WORD_W-1:0]  w_segs  [DISPLAY_DIGITS+1];
    logic [COUNT_WIDTH-1:0] w_count [DISPLAY_DIGITS+1];
    t_flags                 w_flags [DISPLAY_DIGITS+1];

    // Accept and classify events
    bcs_front #(
        .DISPLAY_DIGITS (DISPLAY_DIGITS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_button_edges (i_button_edges),
        .i_switches     (i_switches),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_push_valid   (w_push_valid),
        .i_push_ready   (w_push_ready),
        .o_count        (w_push_count),
        .o_value        (w_push_value),
        .o_flags        (w_push_flags)
    );

    // Decouple front and display path
    bcs_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  ({w_push_count, w_push_value, w_push_flags}),
        .o_pop_valid  (w_valid[0]),
        .i_pop_ready  (w_ready[0]),
        .o_pop_data   (w_pop_data)
    );

    assign w_count[0] = w_pop_data[DATA_W-1 -: COUNT_WIDTH];
    assign w_value[0] = w_pop_data[FLAGS_W +: COUNT_WIDTH];
    assign w_flags[0] = w_pop_data[FLAGS_W-1:0];
    assign w_segs[0]  = '0;

    // One decimal digit per stage
    for (genvar k = 0; k < DISPLAY_DIGITS; k++) begin : g_digit
        bcs_digit #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .DIGIT_INDEX (k)
        ) u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_value (w_value[k]),
            .i_segs  (w_segs[k]),
            .i_count (w_count[k]),
            .i_flags (w_flags[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_value (w_value[k+1]),
            .o_segs  (w_segs[k+1]),
            .o_count (w_count[k+1]),
            .o_flags (w_flags[k+1])
        );
    end

    // Drive the display beat from the last stage, blank when halted
    assign w_ready[DISPLAY_DIGITS] = !i_stall;
    assign o_valid         = w_valid[DISPLAY_DIGITS];
    assign o_segments_low  = w_flags[DISPLAY_DIGITS].halted ? '0 : w_segs[DISPLAY_DIGITS][31:0];
    assign o_segments_high = w_flags[DISPLAY_DIGITS].halted ? '0 : w_segs[DISPLAY_DIGITS][47:32];
    assign o_led           = w_flags[DISPLAY_DIGITS].led;
    assign o_count_value   = w_count[DISPLAY_DIGITS];
    assign o_halted        = w_flags[DISPLAY_DIGITS].halted;

endmodule
